@@ rtl/fdi_pkg.sv @@
// Package for the finite difference / trapezoid integral block.
// Holds the job record that passes from the front to the back, status codes and helpers.
// No dependencies.
`default_nettype none

package fdi_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 168;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // How a job relates to the run: a short run, the third sample, or later.
    typedef enum logic [1:0] {
        K_SHORT,
        K_FIRST,
        K_MID
    } t_kind;

    // One accepted sample together with the two samples before it.
    typedef struct packed {
        logic signed [DATA_W-1:0] xa;
        logic signed [DATA_W-1:0] ya;
        logic signed [DATA_W-1:0] xb;
        logic signed [DATA_W-1:0] yb;
        logic signed [DATA_W-1:0] xc;
        logic signed [DATA_W-1:0] yc;
        t_kind                    kind;
        logic                     last;
    } t_job;

    // Flags: bit 0 zero spacing, bit 1 saturated. Zero spacing wins.
    function automatic logic [1:0] status_code(input logic [1:0] flags);
        logic [1:0] st;
        if (flags[0]) begin
            st = ST_ZERO;
        end else if (flags[1]) begin
            st = ST_SAT;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

@@ rtl/finite_difference_derivative_integral.sv @@
// Three-point finite differences with a cumulative trapezoid integral over a stream of signed
// Q(31-FRAC_BITS).FRAC_BITS (x, y) samples; results lag the samples by one, the third sample
// of a run gives two results and the last sample closes its run, and a run of one or two
// samples gives a single status-2 result. Each job goes through one restoring divider that
// makes one quotient bit a cycle over a 36 + 2*FRAC_BITS bit quotient (68 bits at Q16.16),
// once for the second derivative and once for each result's slope, plus multiplier and
// integral work. A two-beat job queue lets samples be taken while the divider works.
`default_nettype none

module finite_difference_derivative_integral
    import fdi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_sample, y_sample
    input  wire logic                   s_axis_tlast,   // is_last
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // x_out, y_out, first_deriv,
                                                        // second_deriv, running_integral,
                                                        // status, zero fill
    output logic                        m_axis_tlast    // end_of_run
);

    t_job                     push_job, pop_job;
    logic                     push, pop, full, empty;
    logic signed [DATA_W-1:0] ox, oy, od1, od2, oig;
    logic [1:0]               ost;

    fdi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[31:0]),
        .i_y     (s_axis_tdata[63:32]),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    fdi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_full  (full),
        .o_empty (empty)
    );

    fdi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (pop_job),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_x      (ox),
        .o_y      (oy),
        .o_d1     (od1),
        .o_d2     (od2),
        .o_ig     (oig),
        .o_status (ost),
        .o_eor    (m_axis_tlast)
    );

    // Result beat packing, first field lowest.
    assign m_axis_tdata = {6'b0, ost, oig, od2, od1, oy, ox};

endmodule

`default_nettype wire

@@ rtl/fdi_front.sv @@
// Front end: accepts sample beats, keeps the two-sample window and classifies each sample.
// Depends on fdi_pkg.
`default_nettype none

module fdi_front
    import fdi_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [DATA_W-1:0] i_x,
    input  wire logic signed [DATA_W-1:0] i_y,
    input  wire logic                     i_last,
    input  wire logic                     i_full,
    output logic                          o_push,
    output t_job                          o_job
);

    logic signed [DATA_W-1:0] r_xw0, r_xw1, r_yw0, r_yw1;
    logic [1:0]               r_seen;
    logic                     accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Build the job from the window and the new sample.
    always_comb begin
        o_job.xa   = r_xw0;
        o_job.ya   = r_yw0;
        o_job.xb   = r_xw1;
        o_job.yb   = r_yw1;
        o_job.xc   = i_x;
        o_job.yc   = i_y;
        o_job.last = i_last;
        if (r_seen < 2'd2) begin
            o_job.kind = K_SHORT;
        end else if (r_seen == 2'd2) begin
            o_job.kind = K_FIRST;
        end else begin
            o_job.kind = K_MID;
        end
    end

    // A sample that only fills the window produces no job.
    assign o_push = accept && (r_seen >= 2'd2 || i_last);

    // Window and sample count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            r_xw0  <= '0;
            r_xw1  <= '0;
            r_yw0  <= '0;
            r_yw1  <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_seen <= 2'd0;
                r_xw0  <= '0;
                r_xw1  <= '0;
                r_yw0  <= '0;
                r_yw1  <= '0;
            end else if (r_seen == 2'd0) begin
                r_xw0  <= i_x;
                r_yw0  <= i_y;
                r_seen <= 2'd1;
            end else if (r_seen == 2'd1) begin
                r_xw1  <= i_x;
                r_yw1  <= i_y;
                r_seen <= 2'd2;
            end else begin
                r_xw0  <= r_xw1;
                r_yw0  <= r_yw1;
                r_xw1  <= i_x;
                r_yw1  <= i_y;
                r_seen <= 2'd3;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/fdi_fifo.sv @@
// Two-entry job queue between the front end and the back end.
// Depends on fdi_pkg.
`default_nettype none

module fdi_fifo
    import fdi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/fdi_back.sv @@
// Back end: computes derivatives and the running integral for each job with a shared
// bit-serial divider and two multiplications, and drives the result register. Depends on fdi_pkg.
`default_nettype none

module fdi_back
    import fdi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_job                     i_job,
    input  wire logic                     i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DATA_W-1:0]      o_x,
    output logic signed [DATA_W-1:0]      o_y,
    output logic signed [DATA_W-1:0]      o_d1,
    output logic signed [DATA_W-1:0]      o_d2,
    output logic signed [DATA_W-1:0]      o_ig,
    output logic [1:0]                    o_status,
    output logic                          o_eor
);

    localparam int NUM_W = 36 + 2 * FRAC_BITS;
    localparam int DEN_W = 65;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int PRD_W = 66;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_LD2,
        S_DIV,
        S_PICK,
        S_TMUL,
        S_TADD,
        S_OUT
    } t_state;

    t_state                   r_state;
    t_job                     r_job;
    logic [1:0]               r_res;
    logic                     r_is_d2;
    logic [NUM_W-1:0]         r_quo;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_neg;
    logic [PRD_W-1:0]         r_prod;
    logic                     r_tneg;
    logic signed [DATA_W-1:0] r_d1, r_d2, r_ig, r_acc;
    logic [1:0]               r_f2, r_f;
    logic [1:0]               r_st;

    // Curvature operands.
    logic signed [34:0]       curv_num;
    logic [33:0]              curv_mag;
    logic signed [32:0]       span;
    logic [32:0]              span_mag;

    always_comb begin
        curv_num = 35'(r_job.yc) - (35'(r_job.yb) <<< 1) + 35'(r_job.ya);
        curv_mag = curv_num[34] ? 34'(-curv_num) : curv_num[33:0];
        span     = 33'(r_job.xc) - 33'(r_job.xa);
        span_mag = span[32] ? 33'(-span) : span;
    end

    // Slope operands for the point being reported.
    logic signed [DATA_W-1:0] sp_xa, sp_ya, sp_xb, sp_yb;
    logic signed [32:0]       sl_dy, sl_dx;
    logic [32:0]              sl_dy_mag, sl_dx_mag;

    always_comb begin
        unique case (r_res)
            2'd0: begin
                sp_xa = r_job.xa; sp_ya = r_job.ya; sp_xb = r_job.xb; sp_yb = r_job.yb;
            end
            2'd1: begin
                sp_xa = r_job.xa; sp_ya = r_job.ya; sp_xb = r_job.xc; sp_yb = r_job.yc;
            end
            default: begin
                sp_xa = r_job.xb; sp_ya = r_job.yb; sp_xb = r_job.xc; sp_yb = r_job.yc;
            end
        endcase
        sl_dy     = 33'(sp_yb) - 33'(sp_ya);
        sl_dx     = 33'(sp_xb) - 33'(sp_xa);
        sl_dy_mag = sl_dy[32] ? 33'(-sl_dy) : sl_dy;
        sl_dx_mag = sl_dx[32] ? 33'(-sl_dx) : sl_dx;
    end

    // Trapezoid operands: the segment that ends at the reported point.
    logic signed [DATA_W-1:0] tp_xa, tp_ya, tp_xb, tp_yb;
    logic signed [32:0]       tr_s, tr_dx;
    logic [32:0]              tr_s_mag, tr_dx_mag;

    always_comb begin
        if (r_res == 2'd2) begin
            tp_xa = r_job.xb; tp_ya = r_job.yb; tp_xb = r_job.xc; tp_yb = r_job.yc;
        end else begin
            tp_xa = r_job.xa; tp_ya = r_job.ya; tp_xb = r_job.xb; tp_yb = r_job.yb;
        end
        tr_s      = 33'(tp_ya) + 33'(tp_yb);
        tr_dx     = 33'(tp_xb) - 33'(tp_xa);
        tr_s_mag  = tr_s[32] ? 33'(-tr_s) : tr_s;
        tr_dx_mag = tr_dx[32] ? 33'(-tr_dx) : tr_dx;
    end

    // Divider step: one quotient bit per cycle.
    logic [DEN_W:0] div_try;
    logic           div_ge;

    always_comb begin
        div_try = {r_rem, r_quo[NUM_W-1]};
        div_ge  = (div_try >= {1'b0, r_den});
    end

    // Quotient to a saturated 32-bit signed value, with the zero-spacing rule.
    logic signed [DATA_W-1:0] q_val;
    logic [1:0]               q_flags;
    logic                     q_hi;

    always_comb begin
        q_hi    = |r_quo[NUM_W-1:DATA_W];
        q_flags = 2'b00;
        if (r_den == '0) begin
            q_flags[0] = 1'b1;
            if (r_quo == '0) begin
                q_val = '0;
            end else begin
                q_val = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (r_neg) begin
            if (q_hi || r_quo[DATA_W-1:0] > 32'h8000_0000) begin
                q_flags[1] = 1'b1;
                q_val      = 32'sh8000_0000;
            end else begin
                q_val = -$signed(r_quo[DATA_W-1:0]);
            end
        end else begin
            if (q_hi || r_quo[DATA_W-1]) begin
                q_flags[1] = 1'b1;
                q_val      = 32'sh7FFF_FFFF;
            end else begin
                q_val = $signed(r_quo[DATA_W-1:0]);
            end
        end
    end

    // Trapezoid area, capped at 2^62, and the saturated running sum.
    logic [PRD_W-1:0]         area_sh;
    logic [62:0]              area_mag;
    logic signed [64:0]       area_sum;
    logic signed [DATA_W-1:0] acc_next;
    logic                     acc_sat;

    always_comb begin
        area_sh  = r_prod >> (FRAC_BITS + 1);
        area_mag = (area_sh > (PRD_W'(1) << 62)) ? (63'(1) << 62) : area_sh[62:0];
        if (r_tneg) begin
            area_sum = 65'(r_acc) - $signed({2'b00, area_mag});
        end else begin
            area_sum = 65'(r_acc) + $signed({2'b00, area_mag});
        end
        acc_sat = 1'b0;
        if (area_sum > 65'sh0_7FFF_FFFF) begin
            acc_sat  = 1'b1;
            acc_next = 32'sh7FFF_FFFF;
        end else if (area_sum < -65'sh0_8000_0000) begin
            acc_sat  = 1'b1;
            acc_next = 32'sh8000_0000;
        end else begin
            acc_next = area_sum[DATA_W-1:0];
        end
    end

    // The reported point and whether this is the job's final result.
    logic signed [DATA_W-1:0] pt_x, pt_y;
    logic                     res_final;

    always_comb begin
        unique case (r_res)
            2'd0:    begin pt_x = r_job.xa; pt_y = r_job.ya; end
            2'd1:    begin pt_x = r_job.xb; pt_y = r_job.yb; end
            default: begin pt_x = r_job.xc; pt_y = r_job.yc; end
        endcase
        res_final = (r_job.kind == K_SHORT) || (r_res == 2'd2) ||
                    (r_res == 2'd1 && !r_job.last);
    end

    logic out_free;
    assign out_free = !o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Sequencer, divider, multiplier and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            // A taken beat drops valid unless the next beat is loaded in the same cycle.
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        if (i_job.kind == K_SHORT) begin
                            r_res   <= 2'd2;
                            r_d1    <= '0;
                            r_d2    <= '0;
                            r_ig    <= '0;
                            r_st    <= ST_SHORT;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_prod  <= PRD_W'(span_mag * span_mag);
                    r_state <= S_LD2;
                end
                S_LD2: begin
                    r_quo   <= NUM_W'(curv_mag) << (2 * FRAC_BITS + 2);
                    r_den   <= r_prod[DEN_W-1:0];
                    r_neg   <= curv_num[34];
                    r_rem   <= '0;
                    r_cnt   <= (r_prod == '0) ? '0 : CNT_W'(NUM_W);
                    r_is_d2 <= 1'b1;
                    r_state <= S_DIV;
                end
                S_PICK: begin
                    r_quo   <= NUM_W'(sl_dy_mag) << FRAC_BITS;
                    r_den   <= DEN_W'(sl_dx_mag);
                    r_neg   <= sl_dy[32] != sl_dx[32];
                    r_rem   <= '0;
                    r_cnt   <= (sl_dx_mag == '0) ? '0 : CNT_W'(NUM_W);
                    r_is_d2 <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_rem <= div_ge ? div_try[DEN_W-1:0] - r_den : div_try[DEN_W-1:0];
                        r_quo <= {r_quo[NUM_W-2:0], div_ge};
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else if (r_is_d2) begin
                        r_d2    <= q_val;
                        r_f2    <= q_flags;
                        r_res   <= (r_job.kind == K_FIRST) ? 2'd0 : 2'd1;
                        r_state <= S_PICK;
                    end else begin
                        r_d1 <= q_val;
                        r_f  <= r_f2 | q_flags;
                        if (r_res == 2'd0) begin
                            r_ig    <= '0;
                            r_st    <= status_code(r_f2 | q_flags);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_TMUL: begin
                    r_prod  <= PRD_W'(tr_s_mag * tr_dx_mag);
                    r_tneg  <= tr_s[32] != tr_dx[32];
                    r_state <= S_TADD;
                end
                S_TADD: begin
                    r_acc   <= acc_next;
                    r_ig    <= acc_next;
                    r_st    <= status_code(r_f | {acc_sat, 1'b0});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid  <= 1'b1;
                        o_x      <= pt_x;
                        o_y      <= pt_y;
                        o_d1     <= r_d1;
                        o_d2     <= r_d2;
                        o_ig     <= r_ig;
                        o_status <= r_st;
                        o_eor    <= r_job.last && res_final;
                        if (res_final) begin
                            if (r_job.last) begin
                                r_acc <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_res   <= r_res + 2'd1;
                            r_state <= S_PICK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/fdi_checker.sv @@
// Port-level checks for the finite difference block, bound to the top level.
// Depends on fdi_pkg and finite_difference_derivative_integral.
`default_nettype none

module fdi_checker
    import fdi_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                          && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // A short-run result always closes its run.
    a_short_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[161:160] == ST_SHORT |-> m_axis_tlast)
        else $error("short-run result without end of run");

    // A short-run result carries zero derivatives and integral.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[161:160] == ST_SHORT |-> m_axis_tdata[159:64] == '0)
        else $error("short-run result with nonzero values");

    // The fill bits stay zero.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[167:162] == '0)
        else $error("fill bits set");

    // Nothing is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

bind finite_difference_derivative_integral fdi_checker u_fdi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
